// ===== rtl/rau_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package rau_pkg;
	localparam int OperandWidth = 16;
	localparam int MagWidth = 34;

	typedef enum logic [2:0] {
		OP_ADD = 3'd0,
		OP_SUB = 3'd1,
		OP_MUL = 3'd2,
		OP_DIV = 3'd3,
		OP_LESS = 3'd4,
		OP_GREATER = 3'd5,
		OP_EQUAL = 3'd6,
		OP_NONE = 3'd7
	} op_t;

	typedef struct packed {
		logic [2:0] req_type;
		logic signed [15:0] a_num;
		logic signed [15:0] a_den;
		logic signed [15:0] b_num;
		logic signed [15:0] b_den;
	} req_t;

	typedef struct packed {
		logic signed [31:0] res_num;
		logic signed [31:0] res_den;
		logic cmp_true;
	} rsp_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_LOAD_A,
		ST_GCD,
		ST_DIV,
		ST_STORE_A,
		ST_LOAD_B,
		ST_STORE_B,
		ST_MUL1,
		ST_MUL2,
		ST_COMBINE,
		ST_LOAD_R,
		ST_STORE_R,
		ST_DONE
	} state_t;

	typedef enum logic [1:0] {
		SEL_A,
		SEL_B,
		SEL_R
	} sel_t;

	typedef struct packed {
		logic load;
		sel_t sel;
		logic gcd_step;
		logic div_init;
		logic div_step;
		logic store;
		logic mul1;
		logic mul2;
		logic combine;
		logic done;
	} cmd_t;

	typedef struct packed {
		logic gcd_done;
		logic div_done;
		logic is_zero;
		logic arith;
	} sts_t;
endpackage
`default_nettype wire

// ===== rtl/rational_arithmetic_unit_core.sv =====
// Rational arithmetic unit: start is taken while busy is low; one result per
// item appears for a single cycle with done high and cannot be held off.
// Each of the operand reductions and, for add, sub, mul and div, the result
// reduction skips straight to storing zero for a zero part, else runs one
// binary gcd step per cycle and then two 34-bit restoring divisions of one
// bit per cycle. Two multiply steps and a combine step follow the operand
// reductions, then the result reduction for add, sub, mul and div, then the
// done state, from which the done output is registered.
`timescale 1ns / 1ps
`default_nettype none
module rational_arithmetic_unit_core (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	output logic busy,
	input wire rau_pkg::req_t req,
	output logic done,
	output rau_pkg::rsp_t rsp
);
	import rau_pkg::*;

	cmd_t cmd;
	sts_t sts;

	rau_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .sts(sts), .cmd(cmd)
	);

	rau_dp u_dp (
		.clk(clk), .arst_n(arst_n), .accept(start && !busy), .req(req), .cmd(cmd),
		.sts(sts), .strobe(done), .rsp(rsp)
	);
endmodule
`default_nettype wire

// ===== rtl/rau_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
module rau_ctrl (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	output logic busy,
	input wire rau_pkg::sts_t sts,
	output rau_pkg::cmd_t cmd
);
	import rau_pkg::*;

	state_t state_q, state_d;
	sel_t sel_q, sel_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			sel_q <= SEL_A;
		end else begin
			state_q <= state_d;
			sel_q <= sel_d;
		end
	end

	always_comb begin
		state_d = state_q;
		sel_d = sel_q;
		cmd = '0;
		cmd.sel = sel_q;
		busy = (state_q != ST_IDLE);
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					state_d = ST_LOAD_A;
					sel_d = SEL_A;
				end
			end
			ST_LOAD_A, ST_LOAD_B, ST_LOAD_R: begin
				cmd.load = 1'b1;
				state_d = ST_GCD;
			end
			ST_GCD: begin
				if (sts.is_zero) begin
					case (sel_q)
						SEL_A: state_d = ST_STORE_A;
						SEL_B: state_d = ST_STORE_B;
						default: state_d = ST_STORE_R;
					endcase
				end else if (sts.gcd_done) begin
					cmd.div_init = 1'b1;
					state_d = ST_DIV;
				end else begin
					cmd.gcd_step = 1'b1;
				end
			end
			ST_DIV: begin
				if (sts.div_done) begin
					case (sel_q)
						SEL_A: state_d = ST_STORE_A;
						SEL_B: state_d = ST_STORE_B;
						default: state_d = ST_STORE_R;
					endcase
				end else begin
					cmd.div_step = 1'b1;
				end
			end
			ST_STORE_A: begin
				cmd.store = 1'b1;
				sel_d = SEL_B;
				state_d = ST_LOAD_B;
			end
			ST_STORE_B: begin
				cmd.store = 1'b1;
				state_d = ST_MUL1;
			end
			ST_MUL1: begin
				cmd.mul1 = 1'b1;
				state_d = ST_MUL2;
			end
			ST_MUL2: begin
				cmd.mul2 = 1'b1;
				state_d = ST_COMBINE;
			end
			ST_COMBINE: begin
				cmd.combine = 1'b1;
				if (sts.arith) begin
					sel_d = SEL_R;
					state_d = ST_LOAD_R;
				end else begin
					state_d = ST_DONE;
				end
			end
			ST_STORE_R: begin
				cmd.store = 1'b1;
				state_d = ST_DONE;
			end
			ST_DONE: begin
				cmd.done = 1'b1;
				state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end
endmodule
`default_nettype wire

// ===== rtl/rau_dp.sv =====
`timescale 1ns / 1ps
`default_nettype none
module rau_dp (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic accept,
	input wire rau_pkg::req_t req,
	input wire rau_pkg::cmd_t cmd,
	output rau_pkg::sts_t sts,
	output logic strobe,
	output rau_pkg::rsp_t rsp
);
	import rau_pkg::*;

	localparam int W = MagWidth;

	logic [2:0] op_q;
	logic signed [W:0] an_q, ad_q, bn_q, bd_q, rn_q, rd_q;
	logic signed [W:0] n_q, d_q;
	logic [W-1:0] x_q, y_q;
	logic [5:0] k_q;
	logic [W-1:0] dvd_q, dvs_q, quo_q, rem_q;
	logic [W-1:0] nq_q;
	logic [5:0] cnt_q;
	logic phase_q;
	logic signed [W:0] p1_q, p2_q, p3_q, p4_q;
	logic cmp_q;
	logic strobe_q;

	function automatic logic [W-1:0] magf(input logic signed [W:0] v);
		logic signed [W:0] t;
		t = (v < 0) ? -v : v;
		return t[W-1:0];
	endfunction

	function automatic logic signed [W:0] sx(input logic [15:0] v);
		logic signed [OperandWidth-1:0] t;
		t = v[OperandWidth-1:0];
		return (W+1)'(t);
	endfunction

	function automatic logic signed [W:0] smul(input logic signed [W:0] a,
		input logic signed [W:0] b);
		logic signed [17:0] a_t, b_t;
		logic signed [35:0] p;
		a_t = a[17:0];
		b_t = b[17:0];
		p = a_t * b_t;
		return p[W:0];
	endfunction

	logic [W-1:0] rem_sh;
	logic [W:0] rem_try;
	assign rem_sh = {rem_q[W-2:0], dvd_q[W-1]};
	assign rem_try = {1'b0, rem_sh} - {1'b0, dvs_q};

	logic signed [W:0] sbn;
	assign sbn = (op_q == OP_SUB) ? -bn_q : bn_q;

	assign sts.is_zero = (n_q == 0) || (d_q == 0);
	assign sts.gcd_done = (x_q == y_q);
	assign sts.div_done = (cnt_q == 6'(W)) && phase_q;
	assign sts.arith = (op_q == OP_ADD) || (op_q == OP_SUB) ||
		(op_q == OP_MUL) || (op_q == OP_DIV);

	logic signed [W:0] xn, xd, yn, yd;
	always_comb begin
		xn = (ad_q < 0) ? -an_q : an_q;
		xd = (ad_q < 0) ? -ad_q : ad_q;
		yn = (bd_q < 0) ? -bn_q : bn_q;
		yd = (bd_q < 0) ? -bd_q : bd_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= cmd.done;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q <= req.req_type;
			an_q <= sx(req.a_num);
			ad_q <= sx(req.a_den);
			bn_q <= sx(req.b_num);
			bd_q <= sx(req.b_den);
			cmp_q <= 1'b0;
		end
		if (cmd.load) begin
			k_q <= '0;
			case (cmd.sel)
				SEL_A: begin n_q <= an_q; d_q <= ad_q; x_q <= magf(an_q); y_q <= magf(ad_q); end
				SEL_B: begin n_q <= bn_q; d_q <= bd_q; x_q <= magf(bn_q); y_q <= magf(bd_q); end
				default: begin n_q <= rn_q; d_q <= rd_q; x_q <= magf(rn_q); y_q <= magf(rd_q); end
			endcase
		end
		if (cmd.gcd_step) begin
			if (!x_q[0] && !y_q[0]) begin
				x_q <= x_q >> 1;
				y_q <= y_q >> 1;
				k_q <= k_q + 6'd1;
			end else if (!x_q[0]) begin
				x_q <= x_q >> 1;
			end else if (!y_q[0]) begin
				y_q <= y_q >> 1;
			end else if (x_q > y_q) begin
				x_q <= (x_q - y_q) >> 1;
			end else begin
				y_q <= (y_q - x_q) >> 1;
			end
		end
		if (cmd.div_init) begin
			dvd_q <= magf(n_q);
			dvs_q <= x_q << k_q;
			rem_q <= '0;
			quo_q <= '0;
			cnt_q <= '0;
			phase_q <= 1'b0;
		end
		if (cmd.div_step) begin
			if (cnt_q == 6'(W)) begin
				nq_q <= quo_q;
				dvd_q <= magf(d_q);
				rem_q <= '0;
				quo_q <= '0;
				cnt_q <= '0;
				phase_q <= 1'b1;
			end else begin
				dvd_q <= {dvd_q[W-2:0], 1'b0};
				if (!rem_try[W]) begin
					rem_q <= rem_try[W-1:0];
					quo_q <= {quo_q[W-2:0], 1'b1};
				end else begin
					rem_q <= rem_sh;
					quo_q <= {quo_q[W-2:0], 1'b0};
				end
				cnt_q <= cnt_q + 6'd1;
			end
		end
		if (cmd.store) begin
			logic signed [W:0] rn_v, rd_v;
			rn_v = '0;
			rd_v = '0;
			if (!sts.is_zero) begin
				rn_v = (n_q < 0) ? -$signed({1'b0, nq_q}) : $signed({1'b0, nq_q});
				rd_v = (d_q < 0) ? -$signed({1'b0, quo_q}) : $signed({1'b0, quo_q});
			end
			case (cmd.sel)
				SEL_A: begin an_q <= rn_v; ad_q <= rd_v; end
				SEL_B: begin bn_q <= rn_v; bd_q <= rd_v; end
				default: begin rn_q <= rn_v; rd_q <= rd_v; end
			endcase
		end
		if (cmd.mul1) begin
			case (op_q)
				OP_ADD, OP_SUB: begin
					p1_q <= smul(an_q, bd_q);
					p2_q <= smul(ad_q, sbn);
				end
				OP_MUL: begin
					p1_q <= smul(an_q, bn_q);
					p2_q <= '0;
				end
				OP_DIV: begin
					p1_q <= smul(an_q, bd_q);
					p2_q <= '0;
				end
				default: begin
					p1_q <= smul(xn, yd);
					p2_q <= '0;
				end
			endcase
		end
		if (cmd.mul2) begin
			case (op_q)
				OP_DIV: p3_q <= smul(ad_q, bn_q);
				OP_LESS, OP_GREATER: p3_q <= smul(yn, xd);
				default: p3_q <= smul(ad_q, bd_q);
			endcase
			p4_q <= p1_q + p2_q;
		end
		if (cmd.combine) begin
			rn_q <= '0;
			rd_q <= '0;
			case (op_q)
				OP_ADD, OP_SUB: begin
					if (an_q == 0) begin
						rn_q <= sbn; rd_q <= bd_q;
					end else if (ad_q == bd_q) begin
						rn_q <= an_q + sbn; rd_q <= ad_q;
					end else begin
						rn_q <= p4_q; rd_q <= p3_q;
					end
				end
				OP_MUL, OP_DIV: begin
					rn_q <= p1_q; rd_q <= p3_q;
				end
				OP_LESS: cmp_q <= (ad_q != 0) && (bd_q != 0) && (p1_q < p3_q);
				OP_GREATER: cmp_q <= (ad_q != 0) && (bd_q != 0) && (p1_q > p3_q);
				OP_EQUAL: cmp_q <= (an_q == bn_q) && (ad_q == bd_q);
				default: cmp_q <= 1'b0;
			endcase
		end
	end

	assign strobe = strobe_q;
	assign rsp.res_num = rn_q[31:0];
	assign rsp.res_den = rd_q[31:0];
	assign rsp.cmp_true = cmp_q;
endmodule
`default_nettype wire
